/* rtl/rsq_pkg.sv */
// Shared types, sizes and codes of the policy selectable ready queue.
`default_nettype none

package rsq_pkg;

  // Queue depth and the widths that follow from it
  localparam int unsigned Depth = 16;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned OccW  = 5;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 4;
  localparam logic [CfgIdxW-1:0] CfgPolicy    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgNumQueues = 2'd1;

  // Policy codes; unlisted codes are served in arrival order
  localparam logic [2:0] PolFifo     = 3'd0;
  localparam logic [2:0] PolShortest = 3'd1;
  localparam logic [2:0] PolLongest  = 3'd2;
  localparam logic [2:0] PolPrio     = 3'd3;
  localparam logic [2:0] PolLevel    = 3'd4;

  // Commands
  localparam logic CmdEnq = 1'b0;
  localparam logic CmdDeq = 1'b1;

  // Result status codes
  localparam logic [1:0] StatOk    = 2'd0;
  localparam logic [1:0] StatFull  = 2'd1;
  localparam logic [1:0] StatEmpty = 2'd2;

  // One stored process entry
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] run_time;
    logic [7:0]  prio;
    logic [3:0]  level;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

`default_nettype wire

/* rtl/rsq_ram.sv */
// Generic single write, single read RAM with registered read data.
`default_nettype none

module rsq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/rsq_cmp.sv */
// Shared compare unit: decides whether a scanned entry beats the current best.
`default_nettype none

module rsq_cmp (
  input  wire logic [2:0]           policy_i,
  input  wire logic [3:0]           num_queues_i,
  input  wire rsq_pkg::entry_t      cand_i,
  input  wire rsq_pkg::entry_t      best_i,
  input  wire logic                 qual_i,
  output logic                      take_o,
  output logic                      cand_qual_o
);

  // Level eligibility for the multilevel policy
  assign cand_qual_o = (cand_i.level <= num_queues_i);

  // Strict compares keep ties on the earliest entry
  always_comb begin
    case (policy_i)
      rsq_pkg::PolShortest: take_o = cand_i.run_time < best_i.run_time;
      rsq_pkg::PolLongest:  take_o = cand_i.run_time > best_i.run_time;
      rsq_pkg::PolPrio:     take_o = cand_i.prio > best_i.prio;
      rsq_pkg::PolLevel:    take_o = cand_qual_o && (!qual_i || (cand_i.level > best_i.level));
      default:              take_o = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/policy_selectable_ready_queue_unit.sv */
// Top level of the policy selectable ready queue: sequencer, table and result register.
// Enqueue, full or empty result: the accepted word goes to the response state, which
// loads the result register once the output slot is free. Dequeue: the table is scanned
// for the best entry, later entries shift down one place, then the result is loaded.
// Idle follows the result load; a held result stalls the next result, and thus the input.
// Reset clears the count, sets arrival order and level limit 3; the table is not cleared.
`default_nettype none

module policy_selectable_ready_queue_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration writes
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [rsq_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [rsq_pkg::CfgDataW-1:0]   cfg_data_i,
  // input words
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           cmd_i,
  input  wire logic [7:0]                     proc_id_i,
  input  wire logic [15:0]                    run_time_i,
  input  wire logic [7:0]                     prio_i,
  input  wire logic [3:0]                     queue_level_i,
  // result words
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [1:0]                          status_o,
  output logic [7:0]                          out_id_o,
  output logic [15:0]                         out_time_o,
  output logic [7:0]                          out_prio_o,
  output logic [3:0]                          out_level_o,
  output logic [rsq_pkg::OccW-1:0]            occupancy_o
);

  localparam int unsigned IdxW = rsq_pkg::IdxW;
  localparam int unsigned CntW = rsq_pkg::CntW;
  localparam int unsigned OccW = rsq_pkg::OccW;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StScan  = 4'b0010,
    StShift = 4'b0100,
    StResp  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [2:0]      policy_q;
  logic [3:0]      num_queues_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rd_ptr_q, rd_ptr_d;
  logic            pend_q, pend_d;
  logic [IdxW-1:0] pend_idx_q, pend_idx_d;
  rsq_pkg::entry_t best_q, best_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  logic            qual_q, qual_d;
  logic [1:0]      res_status_q, res_status_d;

  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  rsq_pkg::entry_t ram_wdata;
  rsq_pkg::entry_t ram_rdata;
  logic [rsq_pkg::EntryW-1:0] ram_rdata_raw;

  logic            in_acc;
  logic            rd_issue;
  logic            slot_free;
  logic            take;
  logic            cand_qual;
  logic [3:0]      enq_level;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q     <= rsq_pkg::PolFifo;
      num_queues_q <= 4'd3;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rsq_pkg::CfgPolicy:    policy_q     <= cfg_data_i[2:0];
        rsq_pkg::CfgNumQueues: num_queues_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Entry table
  rsq_ram #(
    .Width (rsq_pkg::EntryW),
    .Depth (rsq_pkg::Depth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_ptr_q[IdxW-1:0]),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = rsq_pkg::entry_t'(ram_rdata_raw);

  // Shared compare unit
  rsq_cmp u_cmp (
    .policy_i     (policy_q),
    .num_queues_i (num_queues_q),
    .cand_i       (ram_rdata),
    .best_i       (best_q),
    .qual_i       (qual_q),
    .take_o       (take),
    .cand_qual_o  (cand_qual)
  );

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign rd_issue   = (rd_ptr_q < count_q);
  assign slot_free  = !out_valid_o || out_ready_i;
  assign enq_level  = (queue_level_i > num_queues_q) ? num_queues_q : queue_level_i;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rd_ptr_d     = rd_ptr_q;
    pend_d       = 1'b0;
    pend_idx_d   = pend_idx_q;
    best_d       = best_q;
    best_idx_d   = best_idx_q;
    qual_d       = qual_q;
    res_status_d = res_status_q;
    ram_we       = 1'b0;
    ram_waddr    = count_q[IdxW-1:0];
    ram_wdata    = '{id: proc_id_i, run_time: run_time_i, prio: prio_i, level: enq_level};

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          best_d       = '0;
          res_status_d = rsq_pkg::StatOk;
          state_d      = StResp;
          if (cmd_i == rsq_pkg::CmdEnq) begin
            if (count_q >= CntW'(rsq_pkg::Depth)) begin
              res_status_d = rsq_pkg::StatFull;
            end else begin
              ram_we  = 1'b1;
              count_d = count_q + CntW'(1);
            end
          end else if (count_q == '0) begin
            res_status_d = rsq_pkg::StatEmpty;
          end else begin
            rd_ptr_d = '0;
            state_d  = StScan;
          end
        end
      end

      StScan: begin
        // issue one read a cycle, compare the word read the cycle before
        if (rd_issue) begin
          pend_d     = 1'b1;
          pend_idx_d = rd_ptr_q[IdxW-1:0];
          rd_ptr_d   = rd_ptr_q + CntW'(1);
        end
        if (pend_q) begin
          if (pend_idx_q == '0) begin
            best_d     = ram_rdata;
            best_idx_d = '0;
            qual_d     = cand_qual || (policy_q != rsq_pkg::PolLevel);
          end else if (take) begin
            best_d     = ram_rdata;
            best_idx_d = pend_idx_q;
            qual_d     = 1'b1;
          end
        end
        if (!rd_issue && !pend_q) begin
          rd_ptr_d = CntW'(best_idx_q) + CntW'(1);
          state_d  = StShift;
        end
      end

      StShift: begin
        // move each later entry down by one place
        if (rd_issue) begin
          pend_d     = 1'b1;
          pend_idx_d = rd_ptr_q[IdxW-1:0];
          rd_ptr_d   = rd_ptr_q + CntW'(1);
        end
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pend_idx_q - IdxW'(1);
          ram_wdata = ram_rdata;
        end
        if (!rd_issue && !pend_q) begin
          count_d = count_q - CntW'(1);
          state_d = StResp;
        end
      end

      StResp: begin
        if (slot_free) begin
          state_d = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= '0;
      rd_ptr_q <= '0;
      pend_q   <= 1'b0;
      qual_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_ptr_q <= rd_ptr_d;
      pend_q   <= pend_d;
      qual_q   <= qual_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_idx_q   <= pend_idx_d;
    best_q       <= best_d;
    best_idx_q   <= best_idx_d;
    res_status_q <= res_status_d;
  end

  // Result register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if ((state_q == StResp) && slot_free) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == StResp) && slot_free) begin
      status_o    <= res_status_q;
      out_id_o    <= best_q.id;
      out_time_o  <= best_q.run_time;
      out_prio_o  <= best_q.prio;
      out_level_o <= best_q.level;
      occupancy_o <= OccW'(count_q);
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(rsq_pkg::Depth))
    else $error("entry count above depth");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (count_q != '0))
    else $error("scan started on an empty table");

  a_shift_above_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StShift) && pend_q) |-> (pend_idx_q > best_idx_q))
    else $error("shift would overwrite entries before the picked one");

  a_enq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (cmd_i == rsq_pkg::CmdEnq) && (count_q < CntW'(rsq_pkg::Depth)))
    |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("enqueue did not advance the count");

endmodule

`default_nettype wire
